/* rtl/multilevel_program_scheduler_defines.svh */
// Assertion macros for the multilevel program scheduler.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef MULTILEVEL_PROGRAM_SCHEDULER_DEFINES_SVH
`define MULTILEVEL_PROGRAM_SCHEDULER_DEFINES_SVH
`ifndef SYNTH
`define MPS_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mps assertion failed");
`define MPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mps assertion failed");
`else
`define MPS_ASSERT_IMP(label, clk, rst, ante, cons)
`define MPS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/mps_pkg.sv */
// Shared types and constants for the multilevel program scheduler.
// No dependencies.
package mps_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int TICK_W = 16;
  localparam int SEQ_W = 32;
  localparam int AGE_W = TICK_W + 1;
  localparam logic [AGE_W-1:0] AGE_NEVER = {1'b1, {TICK_W{1'b0}}};

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [1:0] CLS_RT   = 2'd0;
  localparam logic [1:0] CLS_SO   = 2'd1;
  localparam logic [1:0] CLS_USER = 2'd2;
  localparam logic [1:0] CLS_BAD  = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [5:0]  program_id;
    logic [1:0]  program_class;
    logic [7:0]  priority_req;
    logic [15:0] work_units;
    logic [15:0] start_tick;
    logic [5:0]  name_rank;
  } in_item_t;

  typedef struct packed {
    logic [5:0]        id;
    logic [1:0]        cls;
    logic [7:0]        prio;
    logic [5:0]        name;
    logic [15:0]       work;
    logic [TICK_W-1:0] start;
    logic [TICK_W-1:0] last;
    logic              ran;
    logic [SEQ_W-1:0]  seq;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FREE,
    ST_ADMIT_GO,
    ST_ADMIT_WAIT,
    ST_DISPATCH,
    ST_RT_READ,
    ST_RT_TAKE,
    ST_RUN_READ,
    ST_RUN_EXEC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic accept;
    logic free_step;
    logic admit_start;
    logic rt_push;
    logic dispatch;
    logic rt_take;
    logic run_read;
    logic run_exec;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_load;
    logic in_drop;
    logic free_hit;
    logic scan_busy;
    logic rt_found;
    logic rt_pending;
    logic pick_found;
    logic out_busy;
  } ctl_sts_t;

endpackage

/* rtl/mps_if.sv */
// Valid/ready channel interfaces for scheduler requests and results.
// No dependencies.
interface mps_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [5:0]  program_id;
  logic [1:0]  program_class;
  logic [7:0]  priority_req;
  logic [15:0] work_units;
  logic [15:0] start_tick;
  logic [5:0]  name_rank;

  modport source (output valid, kind, program_id, program_class, priority_req,
                  work_units, start_tick, name_rank, input ready);
  modport sink (input valid, kind, program_id, program_class, priority_req,
                work_units, start_tick, name_rank, output ready);
endinterface

interface mps_out_if;
  logic        valid;
  logic        ready;
  logic        finished;
  logic [5:0]  done_id;
  logic [15:0] finish_tick;
  logic        all_empty;

  modport source (output valid, finished, done_id, finish_tick, all_empty,
                  input ready);
  modport sink (input valid, finished, done_id, finish_tick, all_empty,
                output ready);
endinterface

/* rtl/mps_ram.sv */
// Generic simple dual-port RAM with registered read.
// No dependencies.
module mps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/mps_ctl.sv */
// Scheduler controller: sequences loads, admission scans and dispatch.
// Depends on mps_pkg.
module mps_ctl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mps_pkg::ctl_sts_t sts,
  output mps_pkg::ctl_cmd_t cmd
);

  mps_pkg::state_t state;
  mps_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      mps_pkg::ST_IDLE: begin
        in_ready = !sts.out_busy;
        if (in_valid && !sts.out_busy) begin
          cmd.accept = 1'b1;
          if (sts.in_load) begin
            state_next = sts.in_drop ? mps_pkg::ST_IDLE : mps_pkg::ST_FREE;
          end else begin
            state_next = mps_pkg::ST_ADMIT_GO;
          end
        end
      end
      mps_pkg::ST_FREE: begin
        cmd.free_step = 1'b1;
        if (sts.free_hit) begin
          state_next = mps_pkg::ST_IDLE;
        end
      end
      mps_pkg::ST_ADMIT_GO: begin
        cmd.admit_start = 1'b1;
        state_next = mps_pkg::ST_ADMIT_WAIT;
      end
      mps_pkg::ST_ADMIT_WAIT: begin
        if (!sts.scan_busy) begin
          if (sts.rt_found) begin
            cmd.rt_push = 1'b1;
            state_next = mps_pkg::ST_ADMIT_GO;
          end else begin
            state_next = mps_pkg::ST_DISPATCH;
          end
        end
      end
      mps_pkg::ST_DISPATCH: begin
        if (sts.rt_pending) begin
          state_next = mps_pkg::ST_RT_READ;
        end else begin
          cmd.dispatch = 1'b1;
          state_next = sts.pick_found ? mps_pkg::ST_RUN_READ : mps_pkg::ST_EMIT;
        end
      end
      mps_pkg::ST_RT_READ: begin
        state_next = mps_pkg::ST_RT_TAKE;
      end
      mps_pkg::ST_RT_TAKE: begin
        cmd.rt_take = 1'b1;
        state_next = mps_pkg::ST_RUN_READ;
      end
      mps_pkg::ST_RUN_READ: begin
        cmd.run_read = 1'b1;
        state_next = mps_pkg::ST_RUN_EXEC;
      end
      mps_pkg::ST_RUN_EXEC: begin
        cmd.run_exec = 1'b1;
        state_next = mps_pkg::ST_EMIT;
      end
      mps_pkg::ST_EMIT: begin
        cmd.emit = 1'b1;
        state_next = mps_pkg::ST_IDLE;
      end
      default: begin
        state_next = mps_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/mps_datapath.sv */
// Scheduler datapath: program table, real-time ring, scan and pick logic.
// Depends on mps_pkg, mps_ram and the assertion macro header.
`include "multilevel_program_scheduler_defines.svh"
module mps_datapath (
  input  logic              clk,
  input  logic              rst,
  input  mps_pkg::in_item_t in_item,
  input  mps_pkg::ctl_cmd_t cmd,
  output mps_pkg::ctl_sts_t sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              finished,
  output logic [5:0]        done_id,
  output logic [15:0]       finish_tick,
  output logic              all_empty
);

  logic [mps_pkg::MAX_ENTRIES-1:0] valid;
  logic [mps_pkg::MAX_ENTRIES-1:0] queued;

  mps_pkg::entry_t ent_rd;
  mps_pkg::entry_t ent_wr;
  mps_pkg::entry_t ld_entry;
  mps_pkg::entry_t run_entry;
  logic                        ent_we;
  logic [mps_pkg::IDX_W-1:0]   ent_waddr;
  logic [mps_pkg::IDX_W-1:0]   ent_raddr;

  logic                        ring_we;
  logic [mps_pkg::IDX_W-1:0]   ring_wdata;
  logic [mps_pkg::IDX_W-1:0]   ring_rd;
  logic [mps_pkg::IDX_W-1:0]   ring_tail;
  logic [mps_pkg::IDX_W-1:0]   head_inc;
  logic [mps_pkg::SUM_W-1:0]   tail_sum;

  mps_pkg::in_item_t           lat;
  logic [mps_pkg::TICK_W-1:0]  tick;
  logic [mps_pkg::SEQ_W-1:0]   load_ctr;
  logic [mps_pkg::IDX_W-1:0]   rt_head;
  logic [mps_pkg::CNT_W-1:0]   rt_count;
  logic                        turn;
  logic [mps_pkg::CNT_W-1:0]   vcount;
  logic [mps_pkg::IDX_W-1:0]   free_idx;

  logic [mps_pkg::IDX_W-1:0]   scan_addr;
  logic                        scan_issue;
  logic                        eval_live;
  logic [mps_pkg::IDX_W-1:0]   eval_slot;

  logic                        rt_found;
  logic [mps_pkg::IDX_W-1:0]   rt_best;
  logic [mps_pkg::SEQ_W-1:0]   rt_best_age;
  logic                        so_found;
  logic [mps_pkg::IDX_W-1:0]   so_best;
  logic [7:0]                  so_prio;
  logic [15:0]                 so_work;
  logic [5:0]                  so_name;
  logic                        us_found;
  logic [mps_pkg::IDX_W-1:0]   us_best;
  logic [7:0]                  us_prio;
  logic [mps_pkg::AGE_W-1:0]   us_age;
  logic [5:0]                  us_name;

  logic [mps_pkg::IDX_W-1:0]   run_slot;
  logic                        rt_path;
  logic                        fin_reg;
  logic [5:0]                  fid_reg;

  logic                        e_v;
  logic                        e_q;
  logic                        tick_hit;
  logic                        admit;
  logic                        q_eff;
  logic                        rt_cand;
  logic [mps_pkg::SEQ_W-1:0]   rt_age;
  logic                        rt_better;
  logic                        so_better;
  logic [mps_pkg::AGE_W-1:0]   e_age;
  logic                        us_better;
  logic                        pick_user;
  logic [mps_pkg::IDX_W-1:0]   pick_slot;
  logic                        pick_has;
  logic [15:0]                 work_dec;
  logic                        run_fin;
  logic                        ring_full;

  mps_ram #(.WIDTH(mps_pkg::ENTRY_W), .DEPTH(mps_pkg::MAX_ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wr),
    .raddr (ent_raddr),
    .rdata (ent_rd)
  );

  mps_ram #(.WIDTH(mps_pkg::IDX_W), .DEPTH(mps_pkg::MAX_ENTRIES)) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_tail),
    .wdata (ring_wdata),
    .raddr (rt_head),
    .rdata (ring_rd)
  );

  always_comb begin
    tail_sum = mps_pkg::SUM_W'(rt_head) + mps_pkg::SUM_W'(rt_count);
    if (tail_sum >= mps_pkg::SUM_W'(mps_pkg::MAX_ENTRIES)) begin
      ring_tail = mps_pkg::IDX_W'(tail_sum - mps_pkg::SUM_W'(mps_pkg::MAX_ENTRIES));
    end else begin
      ring_tail = mps_pkg::IDX_W'(tail_sum);
    end
    head_inc = (rt_head == mps_pkg::IDX_W'(mps_pkg::MAX_ENTRIES - 1)) ? '0
             : rt_head + 1'b1;
    ring_full = (rt_count == mps_pkg::CNT_W'(mps_pkg::MAX_ENTRIES));
  end

  always_comb begin
    e_v = valid[eval_slot];
    e_q = queued[eval_slot];
    tick_hit = (ent_rd.start == tick);
    admit = eval_live && e_v && !e_q && (ent_rd.cls != mps_pkg::CLS_RT) && tick_hit;
    q_eff = e_q || admit;
    rt_cand = eval_live && e_v && !e_q && (ent_rd.cls == mps_pkg::CLS_RT) && tick_hit;
    rt_age = load_ctr - ent_rd.seq;
    rt_better = rt_cand && (!rt_found || (rt_age > rt_best_age));
    so_better = eval_live && e_v && q_eff && (ent_rd.cls == mps_pkg::CLS_SO) &&
                (!so_found || (ent_rd.prio > so_prio) ||
                 ((ent_rd.prio == so_prio) &&
                  ((ent_rd.work < so_work) ||
                   ((ent_rd.work == so_work) && (ent_rd.name < so_name)))));
    e_age = ent_rd.ran ? {1'b0, tick - ent_rd.last} : mps_pkg::AGE_NEVER;
    us_better = eval_live && e_v && q_eff && (ent_rd.cls == mps_pkg::CLS_USER) &&
                (!us_found || (ent_rd.prio > us_prio) ||
                 ((ent_rd.prio == us_prio) &&
                  ((e_age > us_age) ||
                   ((e_age == us_age) && (ent_rd.name < us_name)))));
  end

  always_comb begin
    pick_user = turn ? us_found : !so_found;
    pick_slot = pick_user ? us_best : so_best;
    pick_has = pick_user ? us_found : so_found;
  end

  always_comb begin
    work_dec = ent_rd.work - 16'd1;
    run_fin = (work_dec == 16'd0);
    run_entry = ent_rd;
    run_entry.work = work_dec;
    run_entry.last = tick;
    run_entry.ran = 1'b1;

    ld_entry.id = lat.program_id;
    ld_entry.cls = lat.program_class;
    ld_entry.prio = lat.priority_req;
    ld_entry.name = lat.name_rank;
    ld_entry.work = (lat.work_units == 16'd0) ? 16'd1 : lat.work_units;
    ld_entry.start = lat.start_tick;
    ld_entry.last = '0;
    ld_entry.ran = 1'b0;
    ld_entry.seq = load_ctr;

    ent_we = (cmd.free_step && !valid[free_idx]) || cmd.run_exec;
    ent_waddr = cmd.run_exec ? run_slot : free_idx;
    ent_wr = cmd.run_exec ? run_entry : ld_entry;
    ent_raddr = cmd.run_read ? run_slot : scan_addr;

    ring_we = !ring_full &&
              (cmd.rt_push || (cmd.run_exec && rt_path && !run_fin));
    ring_wdata = cmd.rt_push ? rt_best : run_slot;
  end

  always_comb begin
    sts.in_load = (in_item.kind == mps_pkg::KIND_LOAD);
    sts.in_drop = (in_item.program_class == mps_pkg::CLS_BAD) ||
                  (vcount == mps_pkg::CNT_W'(mps_pkg::MAX_ENTRIES));
    sts.free_hit = !valid[free_idx];
    sts.scan_busy = scan_issue || eval_live;
    sts.rt_found = rt_found;
    sts.rt_pending = (rt_count != '0);
    sts.pick_found = pick_has;
    sts.out_busy = out_valid && !out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      queued <= '0;
      tick <= '0;
      load_ctr <= '0;
      rt_head <= '0;
      rt_count <= '0;
      turn <= 1'b0;
      vcount <= '0;
      scan_issue <= 1'b0;
      eval_live <= 1'b0;
      rt_found <= 1'b0;
      so_found <= 1'b0;
      us_found <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        lat <= in_item;
        free_idx <= '0;
      end

      if (cmd.free_step) begin
        if (!valid[free_idx]) begin
          valid[free_idx] <= 1'b1;
          queued[free_idx] <= 1'b0;
          load_ctr <= load_ctr + 1'b1;
          vcount <= vcount + 1'b1;
        end else begin
          free_idx <= free_idx + 1'b1;
        end
      end

      if (cmd.admit_start) begin
        scan_addr <= '0;
        scan_issue <= 1'b1;
        eval_live <= 1'b0;
        rt_found <= 1'b0;
        so_found <= 1'b0;
        us_found <= 1'b0;
      end else begin
        eval_live <= scan_issue;
        eval_slot <= scan_addr;
        if (scan_issue) begin
          if (scan_addr == mps_pkg::IDX_W'(mps_pkg::MAX_ENTRIES - 1)) begin
            scan_issue <= 1'b0;
          end else begin
            scan_addr <= scan_addr + 1'b1;
          end
        end
        if (admit) begin
          queued[eval_slot] <= 1'b1;
        end
        if (rt_better) begin
          rt_found <= 1'b1;
          rt_best <= eval_slot;
          rt_best_age <= rt_age;
        end
        if (so_better) begin
          so_found <= 1'b1;
          so_best <= eval_slot;
          so_prio <= ent_rd.prio;
          so_work <= ent_rd.work;
          so_name <= ent_rd.name;
        end
        if (us_better) begin
          us_found <= 1'b1;
          us_best <= eval_slot;
          us_prio <= ent_rd.prio;
          us_age <= e_age;
          us_name <= ent_rd.name;
        end
      end

      if (cmd.rt_push) begin
        queued[rt_best] <= 1'b1;
        if (!ring_full) begin
          rt_count <= rt_count + 1'b1;
        end
      end

      if (cmd.dispatch) begin
        turn <= !pick_user;
        run_slot <= pick_slot;
        rt_path <= 1'b0;
        fin_reg <= 1'b0;
      end

      if (cmd.rt_take) begin
        run_slot <= ring_rd;
        rt_path <= 1'b1;
        rt_head <= head_inc;
        rt_count <= rt_count - 1'b1;
        fin_reg <= 1'b0;
      end

      if (cmd.run_exec) begin
        fin_reg <= run_fin;
        fid_reg <= ent_rd.id;
        if (run_fin) begin
          valid[run_slot] <= 1'b0;
          queued[run_slot] <= 1'b0;
          vcount <= vcount - 1'b1;
        end else if (rt_path && !ring_full) begin
          rt_count <= rt_count + 1'b1;
        end
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
        finished <= fin_reg;
        done_id <= fin_reg ? fid_reg : 6'd0;
        finish_tick <= fin_reg ? tick : 16'd0;
        all_empty <= (vcount == '0);
        tick <= tick + 1'b1;
      end
    end
  end

  `MPS_ASSERT_IMP(a_ring_within_live, clk, rst, 1'b1, rt_count <= vcount)
  `MPS_ASSERT_IMP(a_run_slot_live, clk, rst, cmd.run_exec, valid[run_slot])
  `MPS_ASSERT_NEXT(a_scan_starts, clk, rst, cmd.admit_start, scan_issue && !eval_live)

endmodule

/* rtl/multilevel_program_scheduler.sv */
// Multilevel program scheduler top level; one transaction in flight at a time.
// Load: first-free slot search, one slot per cycle; a dropped load skips the search.
// Tick: accept, then one entry-table scan plus one more per real-time program
// admitted this tick, then dispatch, run and emit.
// A stalled result holds off the next transaction until it is taken.
// Reset clears all control state synchronously; no clearing pass.
module multilevel_program_scheduler (
  input logic       clk,
  input logic       rst,
  mps_in_if.sink    req,
  mps_out_if.source rsp
);

  mps_pkg::in_item_t in_item;
  mps_pkg::ctl_cmd_t cmd;
  mps_pkg::ctl_sts_t sts;

  always_comb begin
    in_item.kind = req.kind;
    in_item.program_id = req.program_id;
    in_item.program_class = req.program_class;
    in_item.priority_req = req.priority_req;
    in_item.work_units = req.work_units;
    in_item.start_tick = req.start_tick;
    in_item.name_rank = req.name_rank;
  end

  mps_ctl u_ctl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mps_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_item     (in_item),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .finished    (rsp.finished),
    .done_id     (rsp.done_id),
    .finish_tick (rsp.finish_tick),
    .all_empty   (rsp.all_empty)
  );

endmodule
